@@ hw/rtl/gha_pkg.sv @@
package gha_pkg;

	localparam int MAX_SLOTS_DEF      = 256;
	localparam int NUM_COMPONENTS_DEF = 64;

	localparam int ACT_W  = 3;
	localparam int IDX_W  = 8;
	localparam int VER_W  = 32;
	localparam int COMP_W = 6;
	localparam int STAT_W = 2;
	localparam int LIVE_W = 9;
	localparam int PEND_W = VER_W + IDX_W;

	localparam logic [ACT_W-1:0] ACT_NEW    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ASSIGN = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_MARK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PURGE  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_SLOT   = 2'd2;
	localparam logic [STAT_W-1:0] ST_LIST_FULL = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_NEWV,
		S_PURGE
	} state_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [IDX_W-1:0]  handle_index;
		logic [VER_W-1:0]  handle_version;
		logic [COMP_W-1:0] component;
	} gha_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  out_index;
		logic [VER_W-1:0]  out_version;
		logic              has_component;
		logic [LIVE_W-1:0] live_count;
	} gha_rsp_t;

endpackage

@@ hw/rtl/gha_ram.sv @@
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/generational_handle_allocator_unit.sv @@
// Generational handle allocator.
// Requests arrive on the req channel (valid/ready) and each produces exactly one
// response on the rsp channel (valid/ready), in order. A request is taken only
// while the unit is idle. New from a fresh slot, assign, check, mark and the
// unused codes go through the execute state, where the response is loaded; new
// that reuses a freed slot reads the free stack, then the slot in the pop state,
// and loads the response in the new-version state; purge reads the pending list
// one entry per cycle through its read port, then responds in the execute state.
// The next request can be taken in the cycle after the response is loaded.
// Slot versions and masks live in one RAM; the free stack and the pending list
// share a second RAM, each in its own half.
// Reset clears the counters and the control state only; RAM contents are not
// cleared, since every entry is written before it is read.
// The response sits in an output register. While the receiver stalls, the unit
// still takes the next request and works on it up to its final cycle, where it
// waits until the output register frees up.
module generational_handle_allocator_unit
	import gha_pkg::*;
#(
	parameter int MAX_SLOTS      = MAX_SLOTS_DEF,
	parameter int NUM_COMPONENTS = NUM_COMPONENTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  gha_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output gha_rsp_t rsp
);

	localparam int AW   = $clog2(MAX_SLOTS);
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam int XW   = (AW > IDX_W) ? AW : IDX_W;
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam int LW   = (CW > LIVE_W) ? CW : LIVE_W;
	localparam int CPW  = COMP_W + 1;
	localparam int SW   = VER_W + NUM_COMPONENTS;
	localparam int LDEPTH = 2 * (2 ** AW);

	localparam logic [CW-1:0]  MAX_CNT   = CW'(MAX_SLOTS);
	localparam logic [CPW-1:0] NCOMP_LIM = CPW'(NUM_COMPONENTS);

	state_t   state_q, state_d;
	gha_req_t req_q, req_d;
	logic [CW-1:0] free_cnt_q, free_cnt_d;
	logic [CW-1:0] fresh_cnt_q, fresh_cnt_d;
	logic [CW-1:0] live_q, live_d;
	logic [CW-1:0] pend_cnt_q, pend_cnt_d;
	logic [IDX_W-1:0] pop_idx_q, pop_idx_d;
	logic     rsp_valid_q, rsp_valid_d;
	gha_rsp_t rsp_q, rsp_d;

	logic          s_we, s_re;
	logic [AW-1:0] s_waddr, s_raddr;
	logic [SW-1:0] s_wdata, s_rdata;
	logic          l_we, l_re;
	logic [AW:0]   l_waddr, l_raddr;
	logic [PEND_W-1:0] l_wdata, l_rdata;

	logic out_free;
	logic rsp_load;
	logic [XW-1:0] in_idx_x, q_idx_x, pop_idx_x, ent_idx_x;
	logic [CW-1:0] free_m1, pend_m1;
	logic [CMPW-1:0] fresh_x;
	logic idx_ok, ent_ok, comp_ok;
	logic [NUM_COMPONENTS-1:0] comp_bit, mask_rd, mask_sh;
	logic [IDX_W-1:0] ent_idx;
	logic [VER_W-1:0] ent_ver;
	logic [LW-1:0] live_x;

	gha_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.re   (s_re),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	gha_ram #(
		.WIDTH(PEND_W),
		.DEPTH(LDEPTH)
	) u_list_ram (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.re   (l_re),
		.raddr(l_raddr),
		.rdata(l_rdata)
	);

	always_comb begin
		in_idx_x  = XW'(req.handle_index);
		q_idx_x   = XW'(req_q.handle_index);
		pop_idx_x = XW'(pop_idx_q);
		ent_idx   = l_rdata[IDX_W-1:0];
		ent_ver   = l_rdata[PEND_W-1:IDX_W];
		ent_idx_x = XW'(ent_idx);
		free_m1   = free_cnt_q - 1'b1;
		pend_m1   = pend_cnt_q - 1'b1;
		fresh_x   = CMPW'(fresh_cnt_q);
		idx_ok    = CMPW'(req_q.handle_index) < fresh_x;
		ent_ok    = CMPW'(ent_idx) < fresh_x;
		comp_ok   = {1'b0, req_q.component} < NCOMP_LIM;
		comp_bit  = NUM_COMPONENTS'(1) << req_q.component;
		mask_rd   = s_rdata[NUM_COMPONENTS-1:0];
		mask_sh   = mask_rd >> req_q.component;
		out_free  = !rsp_valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_cnt_q  <= '0;
			fresh_cnt_q <= '0;
			live_q      <= '0;
			pend_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_cnt_q  <= free_cnt_d;
			fresh_cnt_q <= fresh_cnt_d;
			live_q      <= live_d;
			pend_cnt_q  <= pend_cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		pop_idx_q <= pop_idx_d;
		rsp_q     <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		free_cnt_d  = free_cnt_q;
		fresh_cnt_d = fresh_cnt_q;
		live_d      = live_q;
		pend_cnt_d  = pend_cnt_q;
		pop_idx_d   = pop_idx_q;
		rsp_d       = rsp_q;
		rsp_load    = 1'b0;
		req_ready   = 1'b0;
		s_we    = 1'b0;
		s_waddr = q_idx_x[AW-1:0];
		s_wdata = s_rdata;
		s_re    = 1'b0;
		s_raddr = in_idx_x[AW-1:0];
		l_we    = 1'b0;
		l_waddr = {1'b1, pend_cnt_q[AW-1:0]};
		l_wdata = {req_q.handle_version, req_q.handle_index};
		l_re    = 1'b0;
		l_raddr = {1'b1, pend_m1[AW-1:0]};

		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					req_d   = req;
					state_d = S_EXEC;
					case (req.action) inside
						ACT_NEW: begin
							if (free_cnt_q != '0) begin
								l_re       = 1'b1;
								l_raddr    = {1'b0, free_m1[AW-1:0]};
								free_cnt_d = free_m1;
								state_d    = S_POP;
							end
						end
						ACT_ASSIGN, ACT_CHECK: begin
							s_re = 1'b1;
						end
						ACT_PURGE: begin
							if (pend_cnt_q != '0) begin
								l_re       = 1'b1;
								pend_cnt_d = pend_m1;
								state_d    = S_PURGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				pop_idx_d = ent_idx;
				s_re      = 1'b1;
				s_raddr   = ent_idx_x[AW-1:0];
				state_d   = S_NEWV;
			end
			S_NEWV: begin
				if (out_free) begin
					rsp_load = 1'b1;
					if (live_q < MAX_CNT) begin
						live_d = live_q + 1'b1;
					end
					rsp_d.status        = ST_OK;
					rsp_d.out_index     = pop_idx_x[IDX_W-1:0];
					rsp_d.out_version   = s_rdata[SW-1 -: VER_W];
					rsp_d.has_component = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_PURGE: begin
				if (ent_ok) begin
					s_we    = 1'b1;
					s_waddr = ent_idx_x[AW-1:0];
					s_wdata = {ent_ver + 1'b1, {NUM_COMPONENTS{1'b0}}};
					if (free_cnt_q < MAX_CNT) begin
						l_we       = 1'b1;
						l_waddr    = {1'b0, free_cnt_q[AW-1:0]};
						l_wdata    = {{VER_W{1'b0}}, ent_idx};
						free_cnt_d = free_cnt_q + 1'b1;
					end
					if (live_q != '0) begin
						live_d = live_q - 1'b1;
					end
				end
				if (pend_cnt_q != '0) begin
					l_re       = 1'b1;
					pend_cnt_d = pend_m1;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					rsp_load            = 1'b1;
					rsp_d.status        = ST_OK;
					rsp_d.out_index     = '0;
					rsp_d.out_version   = '0;
					rsp_d.has_component = 1'b0;
					state_d = S_IDLE;
					case (req_q.action) inside
						ACT_NEW: begin
							if (fresh_cnt_q < MAX_CNT) begin
								s_we    = 1'b1;
								s_waddr = fresh_cnt_q[AW-1:0];
								s_wdata = '0;
								rsp_d.out_index = fresh_x[IDX_W-1:0];
								fresh_cnt_d = fresh_cnt_q + 1'b1;
								if (live_q < MAX_CNT) begin
									live_d = live_q + 1'b1;
								end
							end else begin
								rsp_d.status = ST_NO_SLOT;
							end
						end
						ACT_ASSIGN: begin
							if (!idx_ok) begin
								rsp_d.status = ST_BAD_INDEX;
							end else if (comp_ok) begin
								s_we    = 1'b1;
								s_wdata = {s_rdata[SW-1 -: VER_W], mask_rd | comp_bit};
							end
						end
						ACT_CHECK: begin
							if (!idx_ok) begin
								rsp_d.status = ST_BAD_INDEX;
							end else begin
								rsp_d.has_component = comp_ok & mask_sh[0];
							end
						end
						ACT_MARK: begin
							if (!idx_ok) begin
								rsp_d.status = ST_BAD_INDEX;
							end else if (pend_cnt_q >= MAX_CNT) begin
								rsp_d.status = ST_LIST_FULL;
							end else begin
								l_we       = 1'b1;
								pend_cnt_d = pend_cnt_q + 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		live_x = LW'(live_d);
		if (rsp_load) begin
			rsp_d.live_count = live_x[LIVE_W-1:0];
		end

		rsp_valid_d = rsp_valid_q;
		if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end
		if (rsp_load) begin
			rsp_valid_d = 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!s_we && !l_we))
		else $error("RAM write issued while idle");

	a_list_halves: assert property (@(posedge clk) disable iff (!arst_n)
		(l_we && l_re) |-> (l_waddr[AW] != l_raddr[AW]))
		else $error("free stack and pending list accessed in the same half");

	a_counts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_cnt_q <= MAX_CNT) && (fresh_cnt_q <= MAX_CNT) &&
		(free_cnt_q <= MAX_CNT) && (live_q <= MAX_CNT))
		else $error("counter beyond slot count");

	a_pop_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> ($past(state_q) == S_IDLE))
		else $error("free stack pop not started by a transfer");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> $stable(rsp_q))
		else $error("stalled response overwritten");

endmodule
